### rtl/c_escape_sequence_decoder_assert.svh
// assertion macros for the escape decoder top level
// expects clk and rst_n in the scope of each use
`ifndef C_ESCAPE_SEQUENCE_DECODER_ASSERT_SVH
`define C_ESCAPE_SEQUENCE_DECODER_ASSERT_SVH

// same-cycle implication
`define CED_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("escape decoder check failed");

// next-cycle implication
`define CED_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("escape decoder check failed");

`endif

### rtl/ced_pkg.sv
// types, codes and lookup functions for the escape decoder
// used by the decode stage, the result queue and the top level
package ced_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_HEX_MARK  = 8'h78;
  localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESCAPE  = 3'd1,
    MODE_HEX     = 3'd2,
    MODE_OCTAL   = 3'd3,
    MODE_DISCARD = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_STRAY   = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] byte_out;
    status_t    status;
    logic       last_out;
  } res_t;

  // results of one decode step, r0 goes out first
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // simple escape letter to byte, msb set on a hit
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] m;
    begin
      case (c)
        8'h27:   m = {1'b1, 8'h27};
        8'h22:   m = {1'b1, 8'h22};
        8'h3F:   m = {1'b1, 8'h3F};
        8'h61:   m = {1'b1, 8'h07};
        8'h6E:   m = {1'b1, 8'h0A};
        8'h66:   m = {1'b1, 8'h0C};
        8'h62:   m = {1'b1, 8'h08};
        8'h72:   m = {1'b1, 8'h0D};
        8'h74:   m = {1'b1, 8'h09};
        8'h76:   m = {1'b1, 8'h0B};
        8'h5C:   m = {1'b1, 8'h5C};
        default: m = 9'd0;
      endcase
      return m;
    end
  endfunction

  // hex digit value, msb set when c is a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    logic [7:0] t;
    begin
      d = 5'd0;
      t = 8'd0;
      if (c inside {[8'h30:8'h39]}) begin
        t = c - 8'h30;
        d = {1'b1, t[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
        t = c - 8'h57;
        d = {1'b1, t[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
        t = c - 8'h37;
        d = {1'b1, t[3:0]};
      end
      return d;
    end
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return (c inside {[8'h30:8'h37]});
  endfunction

endpackage

### rtl/ced_in_if.sv
// input channel: one raw literal byte per word
// depends on nothing but the clock domain of its users
interface ced_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_literal;

  modport source (output valid, output char_in, output end_of_literal, input ready);
  modport sink   (input valid, input char_in, input end_of_literal, output ready);
endinterface

// result channel: one decoded byte with status per word
interface ced_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic [1:0] status;
  logic       last_out;

  modport source (output valid, output byte_out, output status, output last_out, input ready);
  modport sink   (input valid, input byte_out, input status, input last_out, output ready);
endinterface

### rtl/ced_decode.sv
// decode step: mode, accumulator and digit count, plus the per-byte decision
// depends on ced_pkg
module ced_decode
  import ced_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] char_in,
  input  logic       end_of_literal,
  output push_t      push
);

  mode_t      mode_r, mode_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [1:0] ocnt_r, ocnt_nxt;

  // normal-mode handling, also used for the byte that ends a numeric escape
  logic  norm_emit;
  res_t  norm_res;
  mode_t norm_mode;

  always_comb begin
    if (char_in == CH_BACKSLASH) begin
      norm_emit = end_of_literal;
      norm_res  = '{byte_out: 8'd0, status: ST_STRAY, last_out: 1'b1};
      norm_mode = end_of_literal ? MODE_NORMAL : MODE_ESCAPE;
    end else begin
      norm_emit = 1'b1;
      norm_res  = '{byte_out: char_in, status: ST_OK, last_out: end_of_literal};
      norm_mode = MODE_NORMAL;
    end
  end

  logic [8:0] esc;
  logic [4:0] hd;
  logic [7:0] hex_acc;
  logic [7:0] oct_acc;
  logic [1:0] ocnt_inc;

  assign esc      = esc_map(char_in);
  assign hd       = hex_digit(char_in);
  assign hex_acc  = {acc_r[3:0], hd[3:0]};
  assign oct_acc  = {acc_r[4:0], char_in[2:0]};
  assign ocnt_inc = ocnt_r + 2'd1;

  // next state and results
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    ocnt_nxt = ocnt_r;
    push.n   = 2'd0;
    push.r0  = '{byte_out: 8'd0, status: ST_OK, last_out: 1'b0};
    push.r1  = '{byte_out: 8'd0, status: ST_OK, last_out: 1'b0};
    case (mode_r)
      MODE_ESCAPE: begin
        if (esc[8]) begin
          push.n   = 2'd1;
          push.r0  = '{byte_out: esc[7:0], status: ST_OK, last_out: end_of_literal};
          mode_nxt = MODE_NORMAL;
        end else if (char_in == CH_HEX_MARK) begin
          acc_nxt = 8'd0;
          if (end_of_literal) begin
            push.n   = 2'd1;
            push.r0  = '{byte_out: 8'd0, status: ST_OK, last_out: 1'b1};
            mode_nxt = MODE_NORMAL;
          end else begin
            mode_nxt = MODE_HEX;
          end
        end else if (is_octal(char_in)) begin
          acc_nxt  = {5'd0, char_in[2:0]};
          ocnt_nxt = 2'd1;
          if (end_of_literal) begin
            push.n   = 2'd1;
            push.r0  = '{byte_out: {5'd0, char_in[2:0]}, status: ST_OK, last_out: 1'b1};
            mode_nxt = MODE_NORMAL;
          end else begin
            mode_nxt = MODE_OCTAL;
          end
        end else begin
          push.n   = 2'd1;
          push.r0  = '{byte_out: 8'd0, status: ST_UNKNOWN, last_out: 1'b1};
          mode_nxt = end_of_literal ? MODE_NORMAL : MODE_DISCARD;
        end
      end
      MODE_HEX: begin
        if (hd[4]) begin
          acc_nxt = hex_acc;
          if (end_of_literal) begin
            push.n   = 2'd1;
            push.r0  = '{byte_out: hex_acc, status: ST_OK, last_out: 1'b1};
            mode_nxt = MODE_NORMAL;
          end
        end else begin
          push.n   = norm_emit ? 2'd2 : 2'd1;
          push.r0  = '{byte_out: acc_r, status: ST_OK, last_out: 1'b0};
          push.r1  = norm_res;
          mode_nxt = norm_mode;
        end
      end
      MODE_OCTAL: begin
        if (is_octal(char_in)) begin
          acc_nxt  = oct_acc;
          ocnt_nxt = ocnt_inc;
          if (end_of_literal || (ocnt_inc >= OCT_MAX_DIGITS)) begin
            push.n   = 2'd1;
            push.r0  = '{byte_out: oct_acc, status: ST_OK, last_out: end_of_literal};
            mode_nxt = MODE_NORMAL;
          end
        end else begin
          push.n   = norm_emit ? 2'd2 : 2'd1;
          push.r0  = '{byte_out: acc_r, status: ST_OK, last_out: 1'b0};
          push.r1  = norm_res;
          mode_nxt = norm_mode;
        end
      end
      MODE_DISCARD: begin
        if (end_of_literal) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      default: begin
        // normal text, and any unused mode code
        push.n   = norm_emit ? 2'd1 : 2'd0;
        push.r0  = norm_res;
        mode_nxt = norm_mode;
      end
    endcase
  end

  // state registers, advance only on a consumed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= 8'd0;
      ocnt_r <= 2'd0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

endmodule

### rtl/ced_queue.sv
// result queue: takes up to two results a cycle, sends one word a cycle while the receiver is ready
// depends on ced_pkg and ced_out_if
module ced_queue
  import ced_pkg::*;
#(
  parameter int unsigned QDEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  push_t                        push,
  output logic [$clog2(QDEPTH+1)-1:0]  count,
  ced_out_if.source                    out_ch
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  res_t          mem [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    n_wr;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign n_wr      = wr_en ? push.n : 2'd0;
  assign pop       = out_ch.valid && out_ch.ready;
  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    case (n_wr)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(n_wr) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage writes
  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (n_wr == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

  // head of queue drives the result word
  assign out_ch.valid    = (cnt_r != '0);
  assign out_ch.byte_out = mem[rd_ptr_r].byte_out;
  assign out_ch.status   = mem[rd_ptr_r].status;
  assign out_ch.last_out = mem[rd_ptr_r].last_out;
  assign count           = cnt_r;

endmodule

### rtl/c_escape_sequence_decoder.sv
// C literal escape decoder: input register, decode step, result queue.
// A word is held in the input register until decode fires; its results are queued.
// Throughput: one input word per cycle while decode fires, which needs room for
// two results in the queue; a run of two-result words fills it, then stalls input.
// Reset: synchronous active-low rst_n returns to normal text mode, queue empty.
// depends on ced_pkg, ced_in_if/ced_out_if, ced_decode, ced_queue
module c_escape_sequence_decoder
  import ced_pkg::*;
#(
  parameter int unsigned QDEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  ced_in_if.sink    in_ch,
  ced_out_if.source out_ch
);

`include "c_escape_sequence_decoder_assert.svh"

  localparam int unsigned CW = $clog2(QDEPTH + 1);

  logic          in_v_r, in_v_nxt;
  logic [7:0]    in_char_r;
  logic          in_end_r;
  logic          fire;
  logic          take;
  logic [CW-1:0] q_count;
  push_t         push;

  // decode fires when a word is held and the queue has room for two results
  assign fire        = in_v_r && (q_count <= CW'(QDEPTH - 2));
  assign in_ch.ready = !in_v_r || fire;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (take) begin
      in_v_nxt = 1'b1;
    end else if (fire) begin
      in_v_nxt = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_char_r <= in_ch.char_in;
      in_end_r  <= in_ch.end_of_literal;
    end
  end

  ced_decode u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .char_in        (in_char_r),
    .end_of_literal (in_end_r),
    .push           (push)
  );

  ced_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (fire),
    .push   (push),
    .count  (q_count),
    .out_ch (out_ch)
  );

  // checks
  `CED_ASSERT_IMP(a_q_bound, 1'b1, q_count <= CW'(QDEPTH))
  `CED_ASSERT_IMP(a_err_word, out_ch.valid && (out_ch.status != ST_OK),
                  (out_ch.byte_out == 8'd0) && out_ch.last_out)
  `CED_ASSERT_IMP(a_second_not_last, fire && (push.n == 2'd2), !push.r0.last_out)
  `CED_ASSERT_NXT(a_hold_stalled, in_v_r && !fire, in_v_r && $stable(in_char_r))

endmodule

### verif/ced_decode_checker.sv
`timescale 1ns / 100ps
// watches both channels of the escape decoder, predicts decoded words, compares
// depends on ced_pkg and the ced_in_if / ced_out_if interfaces
module ced_decode_checker
  import ced_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ced_in_if    in_mon,
  ced_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  // decoder state as the predictor sees it
  mode_t      dec_mode   = MODE_NORMAL;
  logic [7:0] num_acc    = 8'h00;
  logic [1:0] oct_digits = 2'd0;

  // decoded words still owed by the block, oldest first
  res_t decoded_due[$];
  int   errors = 0;

  // simple escape letter to byte, bit 8 set on a hit
  function automatic logic [8:0] escape_char(input logic [7:0] c);
    case (c)
      8'h61:   return {1'b1, 8'h07}; // a
      8'h62:   return {1'b1, 8'h08}; // b
      8'h74:   return {1'b1, 8'h09}; // t
      8'h6E:   return {1'b1, 8'h0A}; // n
      8'h76:   return {1'b1, 8'h0B}; // v
      8'h66:   return {1'b1, 8'h0C}; // f
      8'h72:   return {1'b1, 8'h0D}; // r
      8'h22, 8'h27, 8'h3F, CH_BACKSLASH: return {1'b1, c};
      default: return 9'd0;
    endcase
  endfunction

  // hex digit value, bit 4 set when c is a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h61 + 8'd10;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h41 + 8'd10;
    end else begin
      return 5'd0;
    end
    return {1'b1, v[3:0]};
  endfunction

  task automatic push_word(input logic [7:0] b, input status_t st, input logic last);
    res_t r;
    r.byte_out = b;
    r.status   = st;
    r.last_out = last;
    decoded_due.push_back(r);
  endtask

  // byte seen in plain text mode
  task automatic plain_char(input logic [7:0] c, input logic eol);
    if (c == CH_BACKSLASH && eol) begin
      dec_mode = MODE_NORMAL;
      push_word(8'h00, ST_STRAY, 1'b1);
    end else if (c == CH_BACKSLASH) begin
      dec_mode = MODE_ESCAPE;
    end else begin
      dec_mode = MODE_NORMAL;
      push_word(c, ST_OK, eol);
    end
  endtask

  // one accepted input word: update state, queue the words it yields
  task automatic decode_char(input logic [7:0] c, input logic eol);
    logic [8:0] esc;
    logic [4:0] nib;
    logic       oct;
    esc = escape_char(c);
    nib = hex_nibble(c);
    oct = (c[7:3] == 5'b00110);
    case (dec_mode)
      MODE_ESCAPE: begin
        if (esc[8]) begin
          dec_mode = MODE_NORMAL;
          push_word(esc[7:0], ST_OK, eol);
        end else if (c == CH_HEX_MARK) begin
          num_acc = 8'h00;
          if (eol) begin
            dec_mode = MODE_NORMAL;
            push_word(8'h00, ST_OK, 1'b1);
          end else begin
            dec_mode = MODE_HEX;
          end
        end else if (oct) begin
          num_acc    = {5'd0, c[2:0]};
          oct_digits = 2'd1;
          if (eol) begin
            dec_mode = MODE_NORMAL;
            push_word(num_acc, ST_OK, 1'b1);
          end else begin
            dec_mode = MODE_OCTAL;
          end
        end else begin
          // unknown letter: drop the rest of the literal
          dec_mode = eol ? MODE_NORMAL : MODE_DISCARD;
          push_word(8'h00, ST_UNKNOWN, 1'b1);
        end
      end
      MODE_HEX: begin
        if (nib[4]) begin
          // only the last two digits survive
          num_acc = {num_acc[3:0], nib[3:0]};
          if (eol) begin
            dec_mode = MODE_NORMAL;
            push_word(num_acc, ST_OK, 1'b1);
          end
        end else begin
          push_word(num_acc, ST_OK, 1'b0);
          plain_char(c, eol);
        end
      end
      MODE_OCTAL: begin
        if (oct) begin
          num_acc    = {num_acc[4:0], c[2:0]};
          oct_digits = oct_digits + 2'd1;
          if (eol || oct_digits >= OCT_MAX_DIGITS) begin
            dec_mode = MODE_NORMAL;
            push_word(num_acc, ST_OK, eol);
          end
        end else begin
          push_word(num_acc, ST_OK, 1'b0);
          plain_char(c, eol);
        end
      end
      MODE_DISCARD: begin
        if (eol) dec_mode = MODE_NORMAL;
      end
      default: plain_char(c, eol);
    endcase
  endtask

  // sample both channels at the edge, predict first, then compare
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      dec_mode   = MODE_NORMAL;
      num_acc    = 8'h00;
      oct_digits = 2'd0;
      decoded_due.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        decode_char(in_mon.char_in, in_mon.end_of_literal);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (decoded_due.size() == 0) begin
          $display("%0t: result word with none expected: byte %h status %0d last %b",
                   $time, out_mon.byte_out, out_mon.status, out_mon.last_out);
          errors++;
        end else begin
          want = decoded_due.pop_front();
          if (want.byte_out !== out_mon.byte_out) begin
            $display("%0t: byte_out expected %h actual %h",
                     $time, want.byte_out, out_mon.byte_out);
            errors++;
          end
          if (want.status !== out_mon.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, out_mon.status);
            errors++;
          end
          if (want.last_out !== out_mon.last_out) begin
            $display("%0t: last_out expected %b actual %b",
                     $time, want.last_out, out_mon.last_out);
            errors++;
          end
        end
      end
    end
    pending    <= decoded_due.size();
    fail_count <= errors;
  end

endmodule

### verif/c_escape_sequence_decoder_tb.sv
`timescale 1ns / 100ps
// top of the escape decoder testbench: clock, reset, literal stimulus, verdict
// depends on ced_pkg, the channel interfaces, the decoder and ced_decode_checker
module c_escape_sequence_decoder_tb;
  import ced_pkg::*;

  localparam int PERIOD      = 12;
  localparam int RESET_CYC   = 9;
  localparam int PHASE_ITEMS = 180;
  localparam int HOLD_CYC    = 200;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_CYC   = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_requests  = 0;
  int items_sent     = 0;
  int idle_cycles    = 0;
  int fail_count;
  int pending;

  logic [7:0] lit[$];
  string esc_letters = "'\"?abfnrtv\\";
  string hex_chars   = "0123456789abcdefABCDEF";

  ced_in_if  in_w ();
  ced_out_if out_w ();

  c_escape_sequence_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_w),
    .out_ch (out_w)
  );

  ced_decode_checker i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_w),
    .out_mon    (out_w),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #(PERIOD / 2) clk = ~clk;

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_w.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_w.ready <= 1'b0;
      end else begin
        out_w.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // watchdog: too long without any word moving
  always @(posedge clk) begin
    if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct = src_pct;
    sink_stall_pct <= sink_pct;
  endtask

  // offer one word, with random gaps before it, and wait for it to be taken
  task automatic send_char(input logic [7:0] c, input logic eol);
    while ($urandom_range(99) < src_idle_pct) begin
      in_w.valid <= 1'b0;
      @(posedge clk);
    end
    in_w.valid          <= 1'b1;
    in_w.char_in        <= c;
    in_w.end_of_literal <= eol;
    @(posedge clk);
    while (!in_w.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_lit();
    foreach (lit[i]) send_char(lit[i], i == lit.size() - 1);
  endtask

  task automatic send_text(input string s);
    lit.delete();
    for (int i = 0; i < s.len(); i++) lit.push_back(s[i]);
    send_lit();
  endtask

  // mostly well-formed escapes with random content, some noise
  task automatic random_literal();
    int         kind;
    logic [7:0] c;
    lit.delete();
    repeat ($urandom_range(1, 8)) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        do c = 8'($urandom_range(255)); while (c == CH_BACKSLASH);
        lit.push_back(c);
      end else if (kind < 55) begin
        lit.push_back(CH_BACKSLASH);
        lit.push_back(esc_letters[$urandom_range(esc_letters.len() - 1)]);
      end else if (kind < 70) begin
        lit.push_back(CH_BACKSLASH);
        lit.push_back(CH_HEX_MARK);
        repeat ($urandom_range(0, 4))
          lit.push_back(hex_chars[$urandom_range(hex_chars.len() - 1)]);
      end else if (kind < 85) begin
        lit.push_back(CH_BACKSLASH);
        repeat ($urandom_range(1, 3)) lit.push_back(8'(8'h30 + $urandom_range(7)));
      end else if (kind < 93) begin
        lit.push_back(CH_BACKSLASH);
        lit.push_back(8'($urandom_range(255)));
      end else begin
        lit.push_back(8'($urandom_range(255)));
      end
    end
    send_lit();
  endtask

  initial begin
    int goal;
    in_w.valid          = 1'b0;
    in_w.char_in        = 8'h00;
    in_w.end_of_literal = 1'b0;
    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes
    lit = '{8'h00, 8'hFF};
    send_lit();
    // hex mark alone at the end, hex without digits, long hex run
    send_text("\\x");
    send_text("\\xq");
    send_text("\\x1aFn");
    // octal truncated to 8 bits, octal at the end, octal cut by a non-digit
    send_text("\\777\\1");
    send_text("\\18");
    // unknown escape then discarded bytes, stray backslash at the end
    send_text("\\qzz");
    send_text("\\");

    // random literals over the idling phases, the last with a long hold-off
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       set_idling(0, 0);
        1:       set_idling(48, 0);
        2:       set_idling(0, 48);
        3:       set_idling(7, 7);
        default: begin
          set_idling(0, 0);
          hold_requests <= hold_requests + 1;
        end
      endcase
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) random_literal();
    end

    // drain and decide
    in_w.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ced_pkg.sv
rtl/ced_in_if.sv
rtl/ced_decode.sv
rtl/ced_queue.sv
rtl/c_escape_sequence_decoder.sv
verif/ced_decode_checker.sv
verif/c_escape_sequence_decoder_tb.sv
